/* sv/kti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int DUR_W           = 16;
	localparam int TIME_W          = 32;
	localparam int DVD_W           = 32;
	localparam int IN_DATA_W       = 168;
	localparam int OUT_DATA_W      = 144;

	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_RESTART = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;

	localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] CFG_LOOP_FIRST  = 2'd1;
	localparam logic [1:0] CFG_LOOP_LAST   = 2'd2;

	typedef struct packed {
		logic [2:0][15:0] move;
		logic [2:0][15:0] sway;
		logic [7:0]       accel;
		logic [7:0]       pose;
		logic [15:0]      dur;
	} kti_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kti_div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_CYC_FETCH,
		ST_CYC_ADD,
		ST_SKIP_WAIT,
		ST_NXT_FETCH,
		ST_NXT_CAP,
		ST_FDIV,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} kti_state_t;

endpackage
`default_nettype wire

/* sv/kti_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_store
// Keyframe table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kti_store #(
	parameter int DEPTH = kti_pkg::MAX_ENTRIES_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [IDX_W-1:0]         wr_addr,
	input  kti_pkg::kti_entry_t     wr_data,
	input  wire [IDX_W-1:0]         rd_addr,
	output kti_pkg::kti_entry_t     rd_data
);
	import kti_pkg::*;

	kti_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

/* sv/kti_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kti_divider #(
	parameter int DVS_W = 22
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [kti_pkg::DVD_W-1:0]     dividend,
	input  wire [DVS_W-1:0]              divisor,
	output kti_pkg::kti_div_stat_t       stat,
	output logic [kti_pkg::DVD_W-1:0]    quotient,
	output logic [DVS_W-1:0]             remainder
);
	import kti_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The quotient bits shift in behind the dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

/* sv/keyframe_track_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load, restart and unused items are taken in the idle state. A tick is accepted,
// walks the table entry by entry, sums the loop entries and divides when whole loop
// cycles are skipped, fetches the next entry, divides for the factor unless it saturates,
// blends the six components and loads the output, which an output stall can hold back.
// Reset clears the control state, segment start and index and presets the registers;
// the table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Looping keyframe track with a table walk, a shared divider and a multiplier.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator #(
	parameter int MAX_ENTRIES = kti_pkg::MAX_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_index, duration, pose_id, accel_code, sway_x, sway_y, sway_z,
	// move_x, move_y, move_z, now_tick
	input  wire [kti_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// mode
	input  wire [1:0]                         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// pose_now, pose_next, blend_factor, accel_out, sway_out_x, sway_out_y,
	// sway_out_z, move_out_x, move_out_y, move_out_z, current_entry
	output logic [kti_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  wire                               cfg_we,
	input  wire [1:0]                         cfg_index,
	input  wire [6:0]                         cfg_data
);
	import kti_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CYC_W = DUR_W + IDX_W;

	kti_state_t state_q, state_d;

	logic [6:0]        ec_q, lf_q, ll_q;
	logic [TIME_W-1:0] seg_start_q;
	logic [IDX_W-1:0]  seg_idx_q;
	logic [TIME_W-1:0] now_q, t_q;
	logic [IDX_W-1:0]  first_q, last_q, i_q, m_q;
	logic              skipped_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [TIME_W:0]   end_q;
	kti_entry_t        cur_q, nxt_q;
	logic [16:0]       factor_q;
	logic [2:0]        k_q;
	logic signed [35:0] p_s1;
	logic [5:0][15:0]  res_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic              out_valid_q;

	logic              in_fire;
	logic [1:0]        in_mode;
	logic [5:0]        in_idx;
	kti_entry_t        in_entry;
	logic [TIME_W-1:0] in_now;
	logic              wr_en;
	logic [IDX_W-1:0]  rd_addr;
	kti_entry_t        rd_data;
	logic              div_start;
	logic [DVD_W-1:0]  div_dividend;
	logic [CYC_W-1:0]  div_divisor;
	kti_div_stat_t     div_stat;
	logic [DVD_W-1:0]  div_quot;
	logic [CYC_W-1:0]  div_rem;
	logic              load_out;

	logic [DUR_W-1:0]  rd_dur, cur_dur;
	logic [TIME_W:0]   walk_end;
	logic              walk_done;
	logic [TIME_W:0]   diff;
	logic              sat;
	logic [6:0]        cnt_m1;
	logic [IDX_W-1:0]  first_w, last_w;
	logic [15:0]       comp_c, comp_n;
	logic signed [16:0] comp_d;
	logic signed [35:0] p_adj;

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [6:0] v);
		if ({25'b0, v} >= 32'(MAX_ENTRIES)) begin
			return IDX_W'(MAX_ENTRIES - 1);
		end
		return IDX_W'(v);
	endfunction

	function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] x,
			input logic [IDX_W-1:0] fst, input logic [IDX_W-1:0] lst);
		logic [IDX_W:0] n;
		n = {1'b0, x} + 1'b1;
		return (n > {1'b0, lst}) ? fst : n[IDX_W-1:0];
	endfunction

	function automatic logic [15:0] comp_of(input kti_entry_t e, input logic [2:0] k);
		logic [2:0] km;
		km = k - 3'd3;
		return (k < 3'd3) ? e.sway[k[1:0]] : e.move[km[1:0]];
	endfunction

	// Input field decode
	assign in_mode        = s_axis_tuser;
	assign in_idx         = s_axis_tdata[5:0];
	assign in_entry.dur   = s_axis_tdata[21:6];
	assign in_entry.pose  = s_axis_tdata[29:22];
	assign in_entry.accel = s_axis_tdata[37:30];
	assign in_entry.sway  = {s_axis_tdata[85:70], s_axis_tdata[69:54], s_axis_tdata[53:38]};
	assign in_entry.move  = {s_axis_tdata[133:118], s_axis_tdata[117:102],
		s_axis_tdata[101:86]};
	assign in_now         = s_axis_tdata[165:134];
	assign in_fire        = s_axis_tvalid && s_axis_tready;
	assign wr_en          = in_fire && (in_mode == MODE_LOAD)
		&& ({26'b0, in_idx} < 32'(MAX_ENTRIES));

	// Loop bounds; an entry count of zero reads as one.
	assign cnt_m1  = (ec_q == 7'd0) ? 7'd0 : ec_q - 7'd1;
	assign first_w = lf_q[6] ? '0 : clamp_idx(lf_q);
	assign last_w  = (ll_q == 7'h7F) ? clamp_idx(cnt_m1) : (ll_q[6] ? '0 : clamp_idx(ll_q));

	assign rd_dur    = (rd_data.dur == '0) ? DUR_W'(1) : rd_data.dur;
	assign cur_dur   = (cur_q.dur == '0) ? DUR_W'(1) : cur_q.dur;
	assign walk_end  = {1'b0, t_q} + (TIME_W + 1)'(rd_dur);
	assign walk_done = walk_end >= {1'b0, now_q};
	assign diff      = end_q - {1'b0, now_q};
	assign sat       = diff >= (TIME_W + 1)'(cur_dur);

	assign comp_c = comp_of(cur_q, k_q);
	assign comp_n = comp_of(nxt_q, k_q);
	assign comp_d = $signed({comp_c[15], comp_c}) - $signed({comp_n[15], comp_n});
	// Truncation toward zero of the product shifted down by 16.
	assign p_adj  = p_s1 + (p_s1[35] ? 36'sd65535 : 36'sd0);

	kti_store #(
		.DEPTH (MAX_ENTRIES),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(in_idx)),
		.wr_data (in_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kti_divider #(
		.DVS_W (CYC_W)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_mode == MODE_TICK) state_d = ST_FETCH;
			end
			ST_FETCH:     state_d = ST_WALK;
			ST_WALK: begin
				if (walk_done) state_d = ST_NXT_FETCH;
				else if (i_q == first_q && !skipped_q) state_d = ST_CYC_FETCH;
				else state_d = ST_FETCH;
			end
			ST_CYC_FETCH: state_d = (m_q == first_q) ? ST_SKIP_WAIT : ST_CYC_ADD;
			ST_CYC_ADD:   state_d = ST_CYC_FETCH;
			ST_SKIP_WAIT: begin
				if (div_stat.done) state_d = ST_FETCH;
			end
			ST_NXT_FETCH: state_d = ST_NXT_CAP;
			ST_NXT_CAP:   state_d = sat ? ST_MUL : ST_FDIV;
			ST_FDIV: begin
				if (div_stat.done) state_d = ST_MUL;
			end
			ST_MUL:       state_d = ST_ACC;
			ST_ACC:       state_d = (k_q == 3'd5) ? ST_OUT : ST_MUL;
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_addr       = i_q;
		div_start     = 1'b0;
		div_dividend  = now_q - t_q - 32'd1;
		div_divisor   = cyc_q;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE:      s_axis_tready = 1'b1;
			ST_CYC_FETCH: begin
				rd_addr   = m_q;
				div_start = (m_q == first_q);
			end
			ST_NXT_FETCH: rd_addr = step_idx(i_q, first_q, last_q);
			ST_NXT_CAP: begin
				div_start    = !sat;
				div_dividend = {diff[15:0], 16'h0000};
				div_divisor  = CYC_W'(cur_dur);
			end
			ST_OUT:       load_out = !out_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ec_q        <= 7'd1;
			lf_q        <= 7'h7F;
			ll_q        <= 7'h7F;
			seg_start_q <= '0;
			seg_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENTRY_COUNT: ec_q <= cfg_data;
					CFG_LOOP_FIRST:  lf_q <= cfg_data;
					CFG_LOOP_LAST:   ll_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (in_fire && in_mode == MODE_RESTART) begin
				seg_idx_q   <= '0;
				seg_start_q <= in_now;
			end
			if (state_q == ST_WALK && walk_done) begin
				seg_idx_q   <= i_q;
				seg_start_q <= t_q;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q     <= in_now;
				i_q       <= seg_idx_q;
				t_q       <= seg_start_q;
				first_q   <= first_w;
				last_q    <= last_w;
				skipped_q <= 1'b0;
			end
			ST_WALK: begin
				cur_q <= rd_data;
				end_q <= walk_end;
				k_q   <= '0;
				if (!walk_done) begin
					if (i_q == first_q && !skipped_q) begin
						cyc_q <= CYC_W'(rd_dur);
						m_q   <= step_idx(first_q, first_q, last_q);
					end else begin
						i_q <= step_idx(i_q, first_q, last_q);
						t_q <= walk_end[TIME_W-1:0];
					end
				end
			end
			ST_CYC_ADD: begin
				cyc_q <= cyc_q + CYC_W'(rd_dur);
				m_q   <= step_idx(m_q, first_q, last_q);
			end
			ST_SKIP_WAIT: begin
				if (div_stat.done) begin
					t_q       <= now_q - 32'd1 - 32'(div_rem);
					skipped_q <= 1'b1;
				end
			end
			ST_NXT_CAP: begin
				nxt_q    <= rd_data;
				factor_q <= 17'h10000;
			end
			ST_FDIV: begin
				if (div_stat.done) factor_q <= {1'b0, div_quot[15:0]};
			end
			ST_MUL: begin
				p_s1 <= $signed({comp_d[16], comp_d}) * $signed({1'b0, factor_q});
			end
			ST_ACC: begin
				res_q[k_q] <= comp_n + p_adj[31:16];
				k_q        <= k_q + 3'd1;
			end
			ST_OUT: begin
				if (load_out) begin
					out_q <= {1'b0, 6'(i_q), res_q[5], res_q[4], res_q[3], res_q[2],
						res_q[1], res_q[0], cur_q.accel, factor_q, nxt_q.pose, cur_q.pose};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_stat.busy)
		else $error("input ready while the divider is busy");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[32:16] <= 17'h10000))
		else $error("blend factor above one");

	a_seg_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, seg_idx_q} < (IDX_W + 1)'(MAX_ENTRIES))
		else $error("segment index beyond the table");

	a_fdiv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FDIV && div_stat.done) |=> state_q == ST_MUL)
		else $error("factor division result not taken");
`endif

endmodule
`default_nettype wire

/* tb/keyframe_track_interpolator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_test
// Self-checking bench for the keyframe track interpolator. Load, restart and
// tick items are streamed in under several loop settings. Every tick is
// predicted from a private copy of the table, segment state and registers,
// and the pose result is compared field by field.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator_test;
	import kti_pkg::*;

	localparam int ENTRIES     = 64;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE      = 40;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Input word, lowest field last.
	typedef struct packed {
		logic [1:0]       pad;
		logic [31:0]      now_tick;
		logic [2:0][15:0] move;
		logic [2:0][15:0] sway;
		logic [7:0]       accel;
		logic [7:0]       pose;
		logic [15:0]      duration;
		logic [5:0]       entry_index;
	} key_item_t;

	// Result word, lowest field last.
	typedef struct packed {
		logic             pad;
		logic [5:0]       current_entry;
		logic [2:0][15:0] move;
		logic [2:0][15:0] sway;
		logic [7:0]       accel;
		logic [16:0]      blend_factor;
		logic [7:0]       pose_next;
		logic [7:0]       pose_now;
	} pose_result_t;

	class pose_scoreboard;
		kti_entry_t   track[ENTRIES];
		logic [31:0]  seg_start;
		int unsigned  seg_index;
		logic [6:0]   entry_count;
		logic [6:0]   loop_first;
		logic [6:0]   loop_last;
		pose_result_t expected_poses[$];
		int           failures;

		function new();
			seg_start   = 0;
			seg_index   = 0;
			entry_count = 1;
			loop_first  = 7'h7F;
			loop_last   = 7'h7F;
			failures    = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [6:0] value);
			case (idx)
				CFG_ENTRY_COUNT: entry_count = value;
				CFG_LOOP_FIRST:  loop_first = value;
				CFG_LOOP_LAST:   loop_last = value;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_idx(int v);
			if (v < 0) return 0;
			if (v >= ENTRIES) return ENTRIES - 1;
			return v;
		endfunction

		function longint unsigned seg_len(int unsigned i);
			return (track[i].dur == 0) ? 1 : track[i].dur;
		endfunction

		function int unsigned advance(int unsigned i, int unsigned first, int unsigned last);
			return (i + 1 > last) ? first : i + 1;
		endfunction

		function logic [15:0] mix(logic [15:0] cur, logic [15:0] nxt, longint factor);
			longint c, n, p, q;
			c = longint'(signed'(cur));
			n = longint'(signed'(nxt));
			p = (c - n) * factor;
			q = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
			return 16'(n + q);
		endfunction

		// Notes one accepted item; a tick yields the expected pose result.
		function void note_item(logic [1:0] mode, key_item_t it);
			int lf, ll, cnt;
			int unsigned first, last, i, m, nx;
			longint unsigned t, seg_end, now, cyc, factor;
			bit skipped;
			pose_result_t r;
			if (mode == MODE_LOAD) begin
				track[it.entry_index] = '{move: it.move, sway: it.sway, accel: it.accel,
					pose: it.pose, dur: it.duration};
				return;
			end
			if (mode == MODE_RESTART) begin
				seg_index = 0;
				seg_start = it.now_tick;
				return;
			end
			if (mode != MODE_TICK) return;
			lf = int'(signed'(loop_first));
			ll = int'(signed'(loop_last));
			cnt = (entry_count == 0) ? 1 : int'(entry_count);
			first = clamp_idx(lf == -1 ? 0 : lf);
			last = clamp_idx(ll == -1 ? cnt - 1 : ll);
			now = it.now_tick;
			i = seg_index % ENTRIES;
			t = seg_start;
			seg_end = t + seg_len(i);
			skipped = 0;
			while (seg_end < now) begin
				if (i == first && !skipped) begin
					// Jump over whole loop cycles in one go.
					cyc = seg_len(first);
					m = advance(first, first, last);
					while (m != first) begin
						cyc += seg_len(m);
						m = advance(m, first, last);
					end
					t += ((now - t - 1) / cyc) * cyc;
					seg_end = t + seg_len(i);
					skipped = 1;
					if (seg_end >= now) break;
				end
				i = advance(i, first, last);
				t = seg_end;
				seg_end = t + seg_len(i);
			end
			seg_start = t[31:0];
			seg_index = i;
			nx = advance(i, first, last);
			factor = ((seg_end - now) << 16) / seg_len(i);
			if (factor > 65536) factor = 65536;
			r = '0;
			r.pose_now = track[i].pose;
			r.pose_next = track[nx].pose;
			r.blend_factor = factor[16:0];
			r.accel = track[i].accel;
			for (int k = 0; k < 3; k++) begin
				r.sway[k] = mix(track[i].sway[k], track[nx].sway[k], factor);
				r.move[k] = mix(track[i].move[k], track[nx].move[k], factor);
			end
			r.current_entry = i[5:0];
			expected_poses.push_back(r);
		endfunction

		function void compare(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				failures++;
			end
		endfunction

		function void check_result(pose_result_t got);
			pose_result_t e;
			if (expected_poses.size() == 0) begin
				$error("pose result with none expected: %h", got);
				failures++;
				return;
			end
			e = expected_poses.pop_front();
			compare("pose_now", 64'(e.pose_now), 64'(got.pose_now));
			compare("pose_next", 64'(e.pose_next), 64'(got.pose_next));
			compare("blend_factor", 64'(e.blend_factor), 64'(got.blend_factor));
			compare("accel_out", 64'(e.accel), 64'(got.accel));
			compare("sway_out_x", 64'(e.sway[0]), 64'(got.sway[0]));
			compare("sway_out_y", 64'(e.sway[1]), 64'(got.sway[1]));
			compare("sway_out_z", 64'(e.sway[2]), 64'(got.sway[2]));
			compare("move_out_x", 64'(e.move[0]), 64'(got.move[0]));
			compare("move_out_y", 64'(e.move[1]), 64'(got.move[1]));
			compare("move_out_z", 64'(e.move[2]), 64'(got.move[2]));
			compare("current_entry", 64'(e.current_entry), 64'(got.current_entry));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;  // entry_index .. now_tick, as key_item_t
	logic [1:0]            s_axis_tuser;  // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // pose_now .. current_entry, as pose_result_t
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [6:0]            cfg_data;

	pose_scoreboard board;
	bit             idling_on;
	int             long_hold;
	int             quiet_cycles;
	bit             moved;
	logic [31:0]    track_clock;

	keyframe_track_interpolator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Outputs only change at rising edges, so the values seen at the falling
	// edge decide the transfer at the next rising edge.
	always @(negedge clk) begin
		moved = 0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_result(pose_result_t'(m_axis_tdata));
			moved = 1;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			moved = 1;
	end

	always @(posedge clk) begin
		if (moved || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				m_axis_tready <= 0;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
				m_axis_tready <= 1;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	task automatic send_item(logic [1:0] mode, key_item_t it);
		s_axis_tvalid <= 1;
		s_axis_tuser <= mode;
		s_axis_tdata <= it;
		forever begin
			@(negedge clk);
			if (s_axis_tready) break;
		end
		@(posedge clk);
		board.note_item(mode, it);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic write_registers(logic [6:0] count, logic [6:0] first, logic [6:0] last);
		cfg_we <= 1;
		cfg_index <= CFG_ENTRY_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_index <= CFG_LOOP_FIRST;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_LOOP_LAST;
		cfg_data <= last;
		@(posedge clk);
		cfg_we <= 0;
		board.set_register(CFG_ENTRY_COUNT, count);
		board.set_register(CFG_LOOP_FIRST, first);
		board.set_register(CFG_LOOP_LAST, last);
	endtask

	// Waits for every pose result, then lets trailing loads settle.
	task automatic wait_idle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (board.expected_poses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic key_item_t random_entry(logic [5:0] idx);
		key_item_t it;
		it = '0;
		it.entry_index = idx;
		case ($urandom_range(0, 9))
			0:       it.duration = 0;
			1:       it.duration = 16'($urandom);
			2:       it.duration = 16'($urandom_range(0, 2000));
			default: it.duration = 16'($urandom_range(1, 60));
		endcase
		it.pose = 8'($urandom);
		it.accel = 8'($urandom);
		for (int k = 0; k < 3; k++) begin
			it.sway[k] = 16'($urandom);
			it.move[k] = 16'($urandom);
		end
		return it;
	endfunction

	task automatic send_random();
		key_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it = random_entry(6'($urandom));
		case ($urandom_range(0, 19))
			0:       track_clock = $urandom;
			1:       track_clock = track_clock - $urandom_range(1, 100);
			2:       track_clock = track_clock + $urandom_range(0, 100000);
			default: track_clock = track_clock + $urandom_range(0, 80);
		endcase
		it.now_tick = track_clock;
		if (pick < 65)
			send_item(MODE_TICK, it);
		else if (pick < 88)
			send_item(MODE_LOAD, it);
		else if (pick < 96)
			send_item(MODE_RESTART, it);
		else
			send_item(MODE_UNUSED, it);
	endtask

	typedef struct {
		logic [6:0] count;
		logic [6:0] first;
		logic [6:0] last;
	} loop_setting_t;

	initial begin
		key_item_t     it;
		loop_setting_t settings[7];
		settings = '{'{7'd64, 7'h7F, 7'h7F}, '{7'd5, 7'd2, 7'd4}, '{7'd0, 7'h40, 7'h7F},
			'{7'd10, 7'h7F, 7'd3}, '{7'd3, 7'd7, 7'd2}, '{7'd127, 7'd63, 7'h7F},
			'{7'd20, 7'd0, 7'd63}};
		board = new();
		idling_on = 0;
		long_hold = 0;
		quiet_cycles = 0;
		track_clock = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_LOAD;
		cfg_we = 0;
		cfg_index = CFG_ENTRY_COUNT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill the whole table so that no tick can read an unwritten entry.
		for (int e = 0; e < ENTRIES; e++) begin
			it = random_entry(6'(e));
			if (e == 0) begin
				it.duration = 0;
				it.pose = 8'hFF;
				it.sway = {3{16'h8000}};
				it.move = {3{16'h7FFF}};
			end else if (e == 1) begin
				it.duration = 16'hFFFF;
				it.pose = 8'h00;
				it.accel = 8'hFF;
				it.sway = {3{16'h7FFF}};
				it.move = {3{16'h8000}};
			end
			send_item(MODE_LOAD, it);
		end

		// Directed ticks under the reset registers: time zero, zero duration,
		// a time before the segment start and the unused mode.
		it = '0;
		send_item(MODE_TICK, it);
		it.now_tick = 5;
		send_item(MODE_TICK, it);
		it.now_tick = 1000;
		send_item(MODE_RESTART, it);
		it.now_tick = 500;
		send_item(MODE_TICK, it);
		send_item(MODE_UNUSED, it);
		wait_idle();
		write_registers(7'd2, 7'h7F, 7'h7F);
		it.now_tick = 1000;
		send_item(MODE_RESTART, it);
		for (int k = 0; k < 4; k++) begin
			it.now_tick = 1000 + k * 30000;
			send_item(MODE_TICK, it);
		end
		it.now_tick = 32'hFFFF_FFFF;
		send_item(MODE_TICK, it);
		send_item(MODE_TICK, it);
		wait_idle();

		idling_on = 1;
		for (int p = 0; p < 7; p++) begin
			write_registers(settings[p].count, settings[p].first, settings[p].last);
			it = '0;
			track_clock = $urandom_range(0, 1000);
			it.now_tick = track_clock;
			send_item(MODE_RESTART, it);
			if (p == 2) begin
				// Hold the receiver off while items keep coming, so the block
				// fills up and stalls its input.
				long_hold = 900;
				idling_on = 0;
				repeat (60) send_random();
				idling_on = 1;
			end
			if (p == 6) idling_on = 0;
			repeat (210) send_random();
			wait_idle();
		end

		if (board.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
sv/kti_pkg.sv
sv/kti_store.sv
sv/kti_divider.sv
sv/keyframe_track_interpolator.sv
tb/keyframe_track_interpolator_test.sv
